// ----- design/ttse_pkg.sv -----
// shared types and constants for the text terminal screen engine
// no dependencies
package ttse_pkg;

  localparam logic [2:0] OP_BYTE = 3'd0;
  localparam logic [2:0] OP_ERASE = 3'd1;
  localparam logic [2:0] OP_INSCH = 3'd2;
  localparam logic [2:0] OP_DELCH = 3'd3;
  localparam logic [2:0] OP_INSLN = 3'd4;
  localparam logic [2:0] OP_DELLN = 3'd5;
  localparam logic [2:0] OP_CLEAR = 3'd6;
  localparam logic [2:0] OP_READ = 3'd7;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_WRAP = 2'd2;
  localparam logic [1:0] REG_ATTR = 2'd3;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] TAB_MASK = 8'hF8;
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // result beat fields
  typedef struct packed {
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
    logic       scrolled;
    logic       bell;
    logic [6:0] top_line;
    logic [5:0] cursor_row;
    logic [6:0] cursor_col;
  } res_t;

endpackage

// ----- design/ttse_cell_ram.sv -----
// cell store: one write port, one registered read port
// depends on nothing
module ttse_cell_ram #(
  parameter int Depth = 10240,
  parameter int AddrW = 14
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);
  logic [15:0] mem [Depth];

  // synchronous write and read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- design/text_terminal_screen_engine_unit.sv -----
// text terminal screen engine top level: sequencer around the cell store
// depends on ttse_pkg and ttse_cell_ram
//
// channel  dir  fields (low bit first)
// s_axis   in   tdata: op, data_byte, count, row, col, end_row, end_col, back_lines
// m_axis   out  tdata: cursor_col, cursor_row, top_line, bell, scrolled, cell_char, cell_attr
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// steps: each op is accepted, decoded, then its result is loaded; a line feed
// adds a line step and a cell read a read step, a scroll fills LINE_CELLS cells,
// fills write one cell per cycle and copies read then write each cell.
// after reset a clearing pass fills the whole store with blanks; no beat is
// taken until it ends. one item at a time; a result waits in the output
// register and the next beat is taken while it waits.
module text_terminal_screen_engine_unit #(
  parameter int RING_LINES = 128,
  parameter int LINE_CELLS = 80,
  parameter int MAX_ROWS   = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // op, data_byte, count, row, col, end_row, end_col, back_lines
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // cursor_col, cursor_row, top_line, bell, scrolled, cell_char, cell_attr, pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import ttse_pkg::*;

  localparam int Cells = RING_LINES * LINE_CELLS;
  localparam int AW    = $clog2(Cells);
  localparam int LW    = $clog2(RING_LINES);
  localparam int CW    = $clog2(LINE_CELLS + 1);
  localparam int PW    = AW + 2;
  localparam int RowLim = (MAX_ROWS < RING_LINES) ? MAX_ROWS : RING_LINES;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_FILL  = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CWR   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_LNXT  = 4'd9;

  // configuration registers
  logic [6:0] columns_q;
  logic [5:0] rows_q;
  logic       wrap_q;
  logic [7:0] attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 7'd80;
      rows_q    <= 6'd25;
      wrap_q    <= 1'b1;
      attr_q    <= ATTR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLUMNS: columns_q <= cfg_data_i[6:0];
        REG_ROWS:    rows_q <= cfg_data_i[5:0];
        REG_WRAP:    wrap_q <= cfg_data_i[0];
        REG_ATTR:    attr_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // effective sizes
  logic [CW-1:0] ncols;
  logic [LW:0]   nrows;
  always_comb begin
    if (columns_q == 7'd0) ncols = CW'(1);
    else if (32'(columns_q) > LINE_CELLS) ncols = CW'(LINE_CELLS);
    else ncols = CW'(columns_q);
    if (rows_q == 6'd0) nrows = (LW+1)'(1);
    else if (32'(rows_q) > RowLim) nrows = (LW+1)'(RowLim);
    else nrows = (LW+1)'(rows_q);
  end

  // state
  logic [3:0]    st_q, st_d;
  logic [CW-1:0] cx_q, cx_d;
  logic [LW:0]   cy_q, cy_d;
  logic [LW-1:0] top_q, top_d;
  logic [55:0]   in_q, in_d;
  res_t          res_q, res_d;
  logic          ov_q, ov_d;
  logic          bell_q, bell_d, scr_q, scr_d;
  logic [7:0]    rc_q, rc_d, ra_q, ra_d;
  // walk: cell cursor counts in a linear position space
  logic [PW-1:0] pos_q, pos_d, end_q, end_d;
  logic signed [PW:0] dist_q, dist_d;  // copy source offset, in cells
  logic [PW-1:0] fe_q, fe_d;           // fill after copy: start
  logic [PW-1:0] fl_q, fl_d;           // fill after copy: last

  // unpacked input
  logic [2:0] f_op;  logic [7:0] f_byte; logic [6:0] f_cnt; logic [5:0] f_row;
  logic [6:0] f_col; logic [5:0] f_erow; logic [6:0] f_ecol; logic [6:0] f_back;
  assign f_op   = in_q[2:0];
  assign f_byte = in_q[10:3];
  assign f_cnt  = in_q[17:11];
  assign f_row  = in_q[23:18];
  assign f_col  = in_q[30:24];
  assign f_erow = in_q[36:31];
  assign f_ecol = in_q[43:37];
  assign f_back = in_q[50:44];

  // memory
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd, rdat;

  ttse_cell_ram #(.Depth(Cells), .AddrW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rdat)
  );

  // screen position to address: pos = line*LINE_CELLS + col counted from the
  // top line, so the address is pos plus the top line offset folded into the
  // ring by compare and subtract
  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [LW-1:0] t);
    logic [PW+1:0] s;
    s = (PW+2)'(p) + (PW+2)'(t) * (PW+2)'(LINE_CELLS);
    if (s >= (PW+2)'(Cells)) s = s - (PW+2)'(Cells);
    if (s >= (PW+2)'(Cells)) s = s - (PW+2)'(Cells);
    return AW'(s);
  endfunction

  logic [15:0] blank;
  assign blank = {attr_q, CH_SPACE};

  // clamped cursor at start
  logic [CW-1:0] cx0; logic [LW:0] cy0;
  logic [CW-1:0] lenv, movev;
  logic [PW-1:0] lbase;
  always_comb begin
    cx0 = (cx_q > ncols - CW'(1)) ? ncols - CW'(1) : cx_q;
    cy0 = (cy_q > nrows - (LW+1)'(1)) ? nrows - (LW+1)'(1) : cy_q;
    lenv = ((CW)'(f_cnt) < ncols - cx0) ? CW'(f_cnt) : ncols - cx0;
    movev = ncols - cx0 - lenv;
    lbase = PW'(cy0) * PW'(LINE_CELLS);
  end

  logic s_hs, m_hs;
  assign s_axis_tready = (st_q == S_IDLE);
  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {2'b00, res_q};

  logic [CW-1:0] nx;
  logic [PW-1:0] sreg, ereg;
  logic [LW-1:0] maxb, bk, rln;
  logic [LW:0]   cyi;

  always_comb begin
    st_d = st_q; cx_d = cx_q; cy_d = cy_q; top_d = top_q; in_d = in_q;
    res_d = res_q; ov_d = ov_q; bell_d = bell_q; scr_d = scr_q;
    rc_d = rc_q; ra_d = ra_q; pos_d = pos_q; end_d = end_q; dist_d = dist_q;
    fe_d = fe_q; fl_d = fl_q;
    we = 1'b0; wa = addr_of(pos_q, top_q); wd = blank; ra = addr_of(pos_q, top_q);
    nx = '0; sreg = '0; ereg = '0; maxb = '0; bk = '0; rln = '0; cyi = '0;
    if (m_hs) ov_d = 1'b0;
    case (st_q)
      S_INIT: begin
        we = 1'b1; wa = AW'(pos_q); wd = {ATTR_RESET, CH_SPACE};
        pos_d = pos_q + PW'(1);
        if (pos_q == PW'(Cells - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_hs) begin
          in_d = s_axis_tdata; st_d = S_DEC;
        end
      end
      S_DEC: begin
        cx_d = cx0; cy_d = cy0;
        bell_d = 1'b0; scr_d = 1'b0; rc_d = '0; ra_d = '0;
        st_d = S_DONE;
        case (f_op)
          OP_BYTE: begin
            if (f_byte == CH_NUL) begin
            end else if (f_byte == CH_CR) begin
              cx_d = '0;
            end else if (f_byte == CH_LF) begin
              st_d = S_LNXT;
            end else if (f_byte == CH_BEL) begin
              bell_d = 1'b1;
            end else if (f_byte == CH_TAB) begin
              nx = CW'((8'(cx0) + 8'd8) & TAB_MASK);
              if (nx < ncols) cx_d = nx;
            end else if (f_byte == CH_BS || f_byte == CH_DEL) begin
              if (cx0 != '0) cx_d = cx0 - CW'(1);
            end else begin
              we = 1'b1; wa = addr_of(lbase + PW'(cx0), top_q); wd = {attr_q, f_byte};
              if (cx0 + CW'(1) >= ncols) begin
                if (wrap_q) begin
                  cx_d = '0; st_d = S_LNXT;
                end else cx_d = ncols - CW'(1);
              end else cx_d = cx0 + CW'(1);
            end
          end
          OP_ERASE: if (lenv != '0) begin
            pos_d = lbase + PW'(cx0); end_d = lbase + PW'(cx0) + PW'(lenv) - PW'(1);
            st_d = S_FILL;
          end
          OP_INSCH: if (lenv != '0) begin
            fe_d = lbase + PW'(cx0); fl_d = lbase + PW'(cx0) + PW'(lenv) - PW'(1);
            if (movev != '0) begin
              // copy downward from the right end
              pos_d = lbase + PW'(ncols) - PW'(1);
              end_d = lbase + PW'(cx0) + PW'(lenv);
              dist_d = -(PW+1)'(lenv); st_d = S_CRD;
            end else begin
              pos_d = fe_d; end_d = fl_d; st_d = S_FILL;
            end
          end
          OP_DELCH: if (lenv != '0) begin
            fe_d = lbase + PW'(cx0) + PW'(movev);
            fl_d = lbase + PW'(ncols) - PW'(1);
            if (movev != '0) begin
              pos_d = lbase + PW'(cx0);
              end_d = lbase + PW'(cx0) + PW'(movev) - PW'(1);
              dist_d = (PW+1)'(lenv); st_d = S_CRD;
            end else begin
              pos_d = fe_d; end_d = fl_d; st_d = S_FILL;
            end
          end
          OP_INSLN, OP_DELLN: if ((LW+1)'(f_row) < nrows) begin
            if (f_op == OP_INSLN) begin
              fe_d = PW'(f_row) * PW'(LINE_CELLS);
              pos_d = PW'(nrows) * PW'(LINE_CELLS) - PW'(1);
              end_d = PW'(f_row) * PW'(LINE_CELLS) + PW'(LINE_CELLS);
              dist_d = -(PW+1)'(LINE_CELLS);
            end else begin
              fe_d = (PW'(nrows) - PW'(1)) * PW'(LINE_CELLS);
              pos_d = PW'(f_row) * PW'(LINE_CELLS);
              end_d = (PW'(nrows) - PW'(1)) * PW'(LINE_CELLS) - PW'(1);
              dist_d = (PW+1)'(LINE_CELLS);
            end
            fl_d = fe_d + PW'(ncols) - PW'(1);
            if ((LW+1)'(f_row) + (LW+1)'(1) < nrows) begin
              st_d = S_CRD;
            end else begin
              pos_d = fe_d; end_d = fl_d; st_d = S_FILL;
            end
          end
          OP_CLEAR: begin
            sreg = PW'(f_row) * PW'(LINE_CELLS) + PW'(f_col);
            ereg = PW'(f_erow) * PW'(LINE_CELLS) + PW'(f_ecol);
            if (ereg >= sreg) begin
              pos_d = sreg; end_d = ereg; st_d = S_FILL;
            end
          end
          default: begin
            if (32'(f_col) < LINE_CELLS) begin
              maxb = LW'(RING_LINES - 32'(nrows));
              bk = (32'(f_back) > 32'(maxb)) ? maxb : LW'(f_back);
              // top line moved back by the offset, wrapping in the ring
              rln = (top_q >= bk) ? top_q - bk
                                  : LW'(32'(top_q) + RING_LINES - 32'(bk));
              ra = addr_of(PW'(f_row) * PW'(LINE_CELLS) + PW'(f_col), rln);
              st_d = S_RD;
            end
          end
        endcase
      end
      S_LNXT: begin
        // line feed; scroll fills the new bottom line
        cyi = cy_q + (LW+1)'(1);
        if (cyi >= nrows) begin
          top_d = (top_q == LW'(RING_LINES - 1)) ? '0 : top_q + LW'(1);
          scr_d = 1'b1;
          pos_d = (PW'(nrows) - PW'(1)) * PW'(LINE_CELLS);
          end_d = pos_d + PW'(LINE_CELLS) - PW'(1);
          st_d = S_FILL;
        end else begin
          cy_d = cyi; st_d = S_DONE;
        end
      end
      S_FILL: begin
        we = 1'b1;
        pos_d = pos_q + PW'(1);
        if (pos_q == end_q) st_d = S_DONE;
      end
      S_CRD: begin
        ra = addr_of(PW'($signed({1'b0, pos_q}) + dist_q), top_q);
        st_d = S_CWR;
      end
      S_CWR: begin
        we = 1'b1; wd = rdat;
        if (pos_q == end_q) begin
          pos_d = fe_q; end_d = fl_q; st_d = S_FILL;
        end else begin
          pos_d = (dist_q < 0) ? pos_q - PW'(1) : pos_q + PW'(1);
          st_d = S_CRD;
        end
      end
      // read data for the decode cycle's address arrives in the next cycle
      S_RD: begin
        rc_d = rdat[7:0]; ra_d = rdat[15:8]; st_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || m_hs) begin
          res_d.cursor_col = 7'(cx_q); res_d.cursor_row = 6'(cy_q);
          res_d.top_line = 7'(top_q); res_d.bell = bell_q; res_d.scrolled = scr_q;
          res_d.cell_char = rc_q; res_d.cell_attr = ra_q;
          ov_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; cx_q <= '0; cy_q <= '0; top_q <= '0; ov_q <= 1'b0;
      pos_q <= '0; bell_q <= 1'b0; scr_q <= 1'b0;
    end else begin
      st_q <= st_d; cx_q <= cx_d; cy_q <= cy_d; top_q <= top_d; ov_q <= ov_d;
      pos_q <= pos_d; bell_q <= bell_d; scr_q <= scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d; res_q <= res_d; rc_q <= rc_d; ra_q <= ra_d; end_q <= end_d;
    dist_q <= dist_d; fe_q <= fe_d; fl_q <= fl_d;
  end
endmodule

// ----- design/ttse_checker.sv -----
// port-level checks for the screen engine
// depends on ttse_pkg; bound to text_terminal_screen_engine_unit
module ttse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import ttse_pkg::*;

  // a result waiting must hold steady
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no second beat is taken right after one
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

  // cursor stays inside the line
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[6:0] < 7'd80)
    else $error("cursor column out of range");
endmodule

bind text_terminal_screen_engine_unit ttse_checker u_ttse_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
